### hw/rtl/rfav_pkg.sv
// ----------------------------------------------------------------------------
// rfav_pkg: shared types and constants of the reachability block
// Field widths, configuration register codes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rfav_pkg;

    localparam int RFAV_MAX_VERTICES = 32;
    localparam int RFAV_MAX_EDGES    = 64;

    localparam int VERTEX_W    = 5;
    localparam int EDGE_W      = 6;
    localparam int SIGN_W      = 2;
    localparam int VCOUNT_W    = 6;
    localparam int ECOUNT_W    = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_COUNT   = 4'd1;

    typedef struct packed {
        logic load;       // store the accepted incidence entry
        logic rd;         // read edge row at the edge address
        logic close;      // one pivot step of the closure at the vertex index
        logic summary;    // form the per-vertex verdict vector
        logic emit;       // load the output register with the vertex index
        logic emit_last;  // the emitted result is the final one of the run
        logic clear;      // drop all stores at the end of a run
    } t_cmd;

    typedef struct packed {
        logic out_busy;   // output register holds a beat that is not taken
    } t_status;

endpackage

### hw/rtl/reachable_from_all_vertices_unit.sv
// ----------------------------------------------------------------------------
// reachable_from_all_vertices_unit: reachability verdict per vertex
// Loads a directed graph as incidence entries, computes its transitive
// closure and reports for each vertex whether all other vertices reach it.
// ----------------------------------------------------------------------------
// Entries are taken one per cycle while no run is in progress.
// After the entry marked last, the edge sweep reads each edge row in turn (if
// any), the closure takes one pivot step per vertex, and the verdict step runs
// before the first result beat loads. Results follow one per cycle while the
// sink is ready; input resumes once the clear step after the final beat ends.
// Reset is synchronous and clears the stores at once through per-row valid bits.
module reachable_from_all_vertices_unit #(
    parameter int MAX_VERTICES = rfav_pkg::RFAV_MAX_VERTICES,
    parameter int MAX_EDGES    = rfav_pkg::RFAV_MAX_EDGES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rfav_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [rfav_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Entry stream.
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [4:0] vertex_index, [10:5] edge_index, [12:11] entry_sign, [15:13] zero
    input  logic [rfav_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  logic                                 i_s_tlast,
    // Result stream.
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [4:0] result_vertex, [5] reachable_from_all, [7:6] zero
    output logic [rfav_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                 o_m_tlast
);
    import rfav_pkg::*;

    localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NVW = $clog2(MAX_VERTICES + 1);
    localparam int NEW = $clog2(MAX_EDGES + 1);

    t_cmd                       w_cmd;
    t_status                    w_status;
    logic [NVW-1:0]             w_nv;
    logic [NEW-1:0]             w_ne;
    logic [EAW-1:0]             w_eaddr;
    logic [VAW-1:0]             w_vidx;
    logic [VERTEX_W-1:0]        w_vertex_index;
    logic [EDGE_W-1:0]          w_edge_index;
    logic signed [SIGN_W-1:0]   w_entry_sign;
    logic [VERTEX_W-1:0]        w_result_vertex;
    logic                       w_reachable_from_all;

    assign o_cfg_ready    = 1'b1;

    assign w_vertex_index = i_s_tdata[VERTEX_W-1:0];
    assign w_edge_index   = i_s_tdata[VERTEX_W+EDGE_W-1:VERTEX_W];
    assign w_entry_sign   = i_s_tdata[VERTEX_W+EDGE_W+SIGN_W-1:VERTEX_W+EDGE_W];

    assign o_m_tdata = {{(OUT_TDATA_W-VERTEX_W-1){1'b0}}, w_reachable_from_all,
                        w_result_vertex};

    rfav_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .VAW          (VAW),
        .EAW          (EAW),
        .NVW          (NVW),
        .NEW          (NEW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .i_nv       (w_nv),
        .i_ne       (w_ne),
        .o_cmd      (w_cmd),
        .o_eaddr    (w_eaddr),
        .o_vidx     (w_vidx)
    );

    rfav_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .VAW          (VAW),
        .EAW          (EAW),
        .NVW          (NVW),
        .NEW          (NEW)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_vertex_index       (w_vertex_index),
        .i_edge_index         (w_edge_index),
        .i_entry_sign         (w_entry_sign),
        .i_cmd                (w_cmd),
        .i_eaddr              (w_eaddr),
        .i_vidx               (w_vidx),
        .i_m_tready           (i_m_tready),
        .o_status             (w_status),
        .o_nv                 (w_nv),
        .o_ne                 (w_ne),
        .o_m_tvalid           (o_m_tvalid),
        .o_result_vertex      (w_result_vertex),
        .o_reachable_from_all (w_reachable_from_all),
        .o_last_result        (o_m_tlast)
    );

endmodule

### hw/rtl/rfav_ctrl.sv
// ----------------------------------------------------------------------------
// rfav_ctrl: run sequencer
// Accepts entries while idle, then steps through the edge sweep, the closure
// pivots, the verdict step and the result beats, and finally clears stores.
// ----------------------------------------------------------------------------
module rfav_ctrl #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 64,
    parameter int VAW          = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    parameter int EAW          = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    parameter int NVW          = $clog2(MAX_VERTICES + 1),
    parameter int NEW          = $clog2(MAX_EDGES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tlast,
    output logic                 o_s_tready,
    input  rfav_pkg::t_status    i_status,
    input  logic [NVW-1:0]       i_nv,
    input  logic [NEW-1:0]       i_ne,
    output rfav_pkg::t_cmd       o_cmd,
    output logic [EAW-1:0]       o_eaddr,
    output logic [VAW-1:0]       o_vidx
);
    import rfav_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_WAIT,
        S_CLOSE,
        S_SUMMARY,
        S_EMIT,
        S_CLEAR
    } t_state;

    t_state         r_state, n_state;
    logic [NEW-1:0] r_ecnt, n_ecnt;
    logic [NVW-1:0] r_vcnt, n_vcnt;
    logic           w_ecnt_end;
    logic           w_vcnt_end;

    assign w_ecnt_end = ((r_ecnt + NEW'(1)) == i_ne);
    assign w_vcnt_end = ((r_vcnt + NVW'(1)) == i_nv);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_eaddr    = r_ecnt[EAW-1:0];
    assign o_vidx     = r_vcnt[VAW-1:0];

    always_comb begin
        n_state = r_state;
        n_ecnt  = r_ecnt;
        n_vcnt  = r_vcnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_s_tlast) begin
                        n_ecnt  = '0;
                        n_state = (i_ne == '0) ? S_WAIT : S_EDGE;
                    end
                end
            end
            S_EDGE: begin
                o_cmd.rd = 1'b1;
                if (w_ecnt_end) begin
                    n_state = S_WAIT;
                end else begin
                    n_ecnt = r_ecnt + NEW'(1);
                end
            end
            S_WAIT: begin
                // The last edge row is folded in during this cycle.
                n_vcnt  = '0;
                n_state = S_CLOSE;
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                if (w_vcnt_end) begin
                    n_state = S_SUMMARY;
                end else begin
                    n_vcnt = r_vcnt + NVW'(1);
                end
            end
            S_SUMMARY: begin
                o_cmd.summary = 1'b1;
                n_vcnt        = '0;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = w_vcnt_end;
                    if (w_vcnt_end) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_vcnt = r_vcnt + NVW'(1);
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ecnt  <= '0;
            r_vcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_ecnt  <= n_ecnt;
            r_vcnt  <= n_vcnt;
        end
    end

    a_edge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |-> (r_ecnt < i_ne))
        else $error("edge sweep address passed the edge count");

    a_close_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLOSE) |-> (r_vcnt < i_nv))
        else $error("closure pivot passed the vertex count");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE))
        else $error("entry stored outside the idle state");

endmodule

### hw/rtl/rfav_datapath.sv
// ----------------------------------------------------------------------------
// rfav_datapath: edge stores, reach rows and result register
// Holds the tail and head masks per edge, folds them into reach rows, runs
// the closure one pivot vertex per cycle and drives the result beat.
// ----------------------------------------------------------------------------
module rfav_datapath #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 64,
    parameter int VAW          = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    parameter int EAW          = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    parameter int NVW          = $clog2(MAX_VERTICES + 1),
    parameter int NEW          = $clog2(MAX_EDGES + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [rfav_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [rfav_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [rfav_pkg::VERTEX_W-1:0]        i_vertex_index,
    input  logic [rfav_pkg::EDGE_W-1:0]          i_edge_index,
    input  logic signed [rfav_pkg::SIGN_W-1:0]   i_entry_sign,
    input  rfav_pkg::t_cmd                       i_cmd,
    input  logic [EAW-1:0]                       i_eaddr,
    input  logic [VAW-1:0]                       i_vidx,
    input  logic                                 i_m_tready,
    output rfav_pkg::t_status                    o_status,
    output logic [NVW-1:0]                       o_nv,
    output logic [NEW-1:0]                       o_ne,
    output logic                                 o_m_tvalid,
    output logic [rfav_pkg::VERTEX_W-1:0]        o_result_vertex,
    output logic                                 o_reachable_from_all,
    output logic                                 o_last_result
);
    import rfav_pkg::*;

    logic [VCOUNT_W-1:0]     r_vertex_count;
    logic [ECOUNT_W-1:0]     r_edge_count;

    logic [MAX_VERTICES-1:0] r_tail_mem [MAX_EDGES];
    logic [MAX_VERTICES-1:0] r_head_mem [MAX_EDGES];
    logic [MAX_EDGES-1:0]    r_row_vld;
    logic [MAX_VERTICES-1:0] r_tail_q;
    logic [MAX_VERTICES-1:0] r_head_q;
    logic                    r_rd_vld_q;
    logic                    r_acc;

    logic [MAX_VERTICES-1:0] r_reach [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_all_ok;

    logic                    r_out_valid;
    logic [VERTEX_W-1:0]     r_out_vertex;
    logic                    r_out_all;
    logic                    r_out_last;

    logic                    w_entry_ok;
    logic [VAW-1:0]          w_vaddr;
    logic [EAW-1:0]          w_waddr;
    logic [MAX_VERTICES-1:0] w_vbit;
    logic                    w_is_tail;
    logic                    w_is_head;
    logic [MAX_VERTICES-1:0] w_inuse;
    logic [MAX_VERTICES-1:0] w_tail_eff;
    logic [MAX_VERTICES-1:0] w_head_eff;
    logic [MAX_VERTICES-1:0] w_pivot;
    logic [MAX_VERTICES-1:0] w_all_ok;

    // Register values out of range are clamped here, not on the write.
    always_comb begin
        if (r_vertex_count == '0) begin
            o_nv = NVW'(1);
        end else if (int'(r_vertex_count) > MAX_VERTICES) begin
            o_nv = NVW'(MAX_VERTICES);
        end else begin
            o_nv = NVW'(r_vertex_count);
        end
        if (int'(r_edge_count) > MAX_EDGES) begin
            o_ne = NEW'(MAX_EDGES);
        end else begin
            o_ne = NEW'(r_edge_count);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_inuse[i] = (i < int'(o_nv));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_W'(1);
            r_edge_count   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[VCOUNT_W-1:0];
                CFG_EDGE_COUNT:   r_edge_count   <= i_cfg_data[ECOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_entry_ok = (int'(i_vertex_index) < MAX_VERTICES) &&
                        (int'(i_edge_index) < MAX_EDGES);
    assign w_vaddr    = VAW'(i_vertex_index);
    assign w_waddr    = EAW'(i_edge_index);
    assign w_vbit     = MAX_VERTICES'(1) << w_vaddr;
    assign w_is_tail  = (i_entry_sign == 2'sb01);
    assign w_is_head  = i_entry_sign[SIGN_W-1];

    // A row that is not valid reads as zero, so its first write fills it whole.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_entry_ok) begin
            if (r_row_vld[w_waddr]) begin
                r_tail_mem[w_waddr][w_vaddr] <= w_is_tail;
                r_head_mem[w_waddr][w_vaddr] <= w_is_head;
            end else begin
                r_tail_mem[w_waddr] <= w_is_tail ? w_vbit : '0;
                r_head_mem[w_waddr] <= w_is_head ? w_vbit : '0;
            end
        end
        if (i_cmd.rd) begin
            r_tail_q   <= r_tail_mem[i_eaddr];
            r_head_q   <= r_head_mem[i_eaddr];
            r_rd_vld_q <= r_row_vld[i_eaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_row_vld <= '0;
        end else if (i_cmd.load && w_entry_ok) begin
            r_row_vld[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 1'b0;
        end else begin
            r_acc <= i_cmd.rd;
        end
    end

    assign w_tail_eff = r_rd_vld_q ? (r_tail_q & w_inuse) : '0;
    assign w_head_eff = r_rd_vld_q ? (r_head_q & w_inuse) : '0;
    assign w_pivot    = r_reach[i_vidx];

    // Edge rows first build the adjacency; pivot steps then close it in place.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int u = 0; u < MAX_VERTICES; u++) begin
                r_reach[u] <= '0;
            end
        end else if (r_acc) begin
            for (int u = 0; u < MAX_VERTICES; u++) begin
                if (w_tail_eff[u]) begin
                    r_reach[u] <= r_reach[u] | w_head_eff;
                end
            end
        end else if (i_cmd.close) begin
            for (int u = 0; u < MAX_VERTICES; u++) begin
                if (r_reach[u][i_vidx]) begin
                    r_reach[u] <= r_reach[u] | w_pivot;
                end
            end
        end
    end

    // A vertex passes when every other vertex in use has it in its reach row.
    always_comb begin
        logic [MAX_VERTICES-1:0] col;
        logic [MAX_VERTICES-1:0] self;
        for (int t = 0; t < MAX_VERTICES; t++) begin
            self = MAX_VERTICES'(1) << t;
            for (int s = 0; s < MAX_VERTICES; s++) begin
                col[s] = r_reach[s][t];
            end
            w_all_ok[t] = &(col | ~w_inuse | self);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.summary) begin
            r_all_ok <= w_all_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_vertex <= VERTEX_W'(i_vidx);
            r_out_all    <= r_all_ok[i_vidx];
            r_out_last   <= i_cmd.emit_last;
        end
    end

    assign o_status.out_busy   = r_out_valid && !i_m_tready;
    assign o_m_tvalid          = r_out_valid;
    assign o_result_vertex     = r_out_vertex;
    assign o_reachable_from_all = r_out_all;
    assign o_last_result       = r_out_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !o_status.out_busy)
        else $error("result loaded over a beat that was not taken");

    a_fold_vs_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc |-> !i_cmd.close)
        else $error("closure pivot overlaps the last edge fold");

    a_clear_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_row_vld == '0))
        else $error("edge rows still valid after the run was cleared");

endmodule

### dv/reachable_from_all_vertices_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reachable_from_all_vertices_unit_tb: self-checking bench for the verdict unit
// Loads incidence entries over the input stream and computes the expected
// verdicts with a behavioral closure. Each output beat is then compared with
// the oldest expected verdict. Directed graphs come first, then random graphs
// under random settings, with input gaps and output stalls.
// ----------------------------------------------------------------------------
module reachable_from_all_vertices_unit_tb;
    import rfav_pkg::*;

    localparam int ITEMS_RANDOM = 250;
    localparam int DRAIN_CYCLES = RFAV_MAX_EDGES + RFAV_MAX_VERTICES + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;

    localparam logic [SIGN_W-1:0] SIGN_NONE   = 2'b00;
    localparam logic [SIGN_W-1:0] SIGN_OUT    = 2'b01;
    localparam logic [SIGN_W-1:0] SIGN_IN_ALT = 2'b10;
    localparam logic [SIGN_W-1:0] SIGN_IN     = 2'b11;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} t_sink_mode;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                reach;
        logic                last;
    } t_verdict;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    // [4:0] vertex_index, [10:5] edge_index, [12:11] entry_sign, [15:13] zero
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // [4:0] result_vertex, [5] reachable_from_all, [7:6] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    reachable_from_all_vertices_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    // Behavioral copy of the graph stores and the two registers.
    logic [RFAV_MAX_VERTICES-1:0] tail_mask [RFAV_MAX_EDGES];
    logic [RFAV_MAX_VERTICES-1:0] head_mask [RFAV_MAX_EDGES];
    logic [VCOUNT_W-1:0]          vertex_cfg;
    logic [ECOUNT_W-1:0]          edge_cfg;

    t_verdict verdict_q [$];
    int       error_count;
    int       cycle_count;
    int       burst_left;
    bit       sender_idles;
    t_verdict got_verdict;
    t_verdict want_verdict;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("reachable_from_all_vertices_unit test failed");
        $finish;
    end

    function automatic int clamp_vertices();
        if (vertex_cfg == 0) return 1;
        if (vertex_cfg > RFAV_MAX_VERTICES) return RFAV_MAX_VERTICES;
        return int'(vertex_cfg);
    endfunction

    function automatic int clamp_edges();
        if (edge_cfg > RFAV_MAX_EDGES) return RFAV_MAX_EDGES;
        return int'(edge_cfg);
    endfunction

    task automatic clear_graph();
        for (int k = 0; k < RFAV_MAX_EDGES; k++) begin
            tail_mask[k] = '0;
            head_mask[k] = '0;
        end
    endtask

    // Closure by a frontier search per source, then one verdict per vertex.
    task automatic solve_reachability();
        logic [RFAV_MAX_VERTICES-1:0] adj   [RFAV_MAX_VERTICES];
        logic [RFAV_MAX_VERTICES-1:0] reach [RFAV_MAX_VERTICES];
        logic [RFAV_MAX_VERTICES-1:0] inuse, seen, frontier, nxt;
        int       nv, ne;
        t_verdict vr;
        nv = clamp_vertices();
        ne = clamp_edges();
        inuse = (nv >= RFAV_MAX_VERTICES) ? '1 : ((32'h1 << nv) - 1);
        for (int u = 0; u < nv; u++) begin
            adj[u] = '0;
            for (int k = 0; k < ne; k++)
                if (tail_mask[k][u]) adj[u] |= head_mask[k] & inuse;
        end
        for (int s = 0; s < nv; s++) begin
            seen     = '0;
            frontier = 32'h1 << s;
            while (frontier != 0) begin
                nxt = '0;
                for (int u = 0; u < nv; u++)
                    if (frontier[u]) nxt |= adj[u];
                nxt      &= ~seen;
                seen     |= nxt;
                frontier  = nxt;
            end
            reach[s] = seen;
        end
        for (int t = 0; t < nv; t++) begin
            vr.vertex = VERTEX_W'(t);
            vr.reach  = 1'b1;
            vr.last   = (t == nv - 1);
            for (int s = 0; s < nv; s++)
                if (s != t && !reach[s][t]) vr.reach = 1'b0;
            verdict_q.push_back(vr);
        end
        clear_graph();
    endtask

    task automatic apply_entry(input logic [VERTEX_W-1:0] v, input logic [EDGE_W-1:0] e,
                               input logic [SIGN_W-1:0] sg, input logic lst);
        tail_mask[e][v] = (sg == SIGN_OUT);
        // Both negative patterns mark the vertex as a head.
        head_mask[e][v] = sg[SIGN_W-1];
        if (lst) solve_reachability();
    endtask

    // One entry beat, possibly preceded by an idle gap when a new burst starts.
    task automatic send_entry(input logic [VERTEX_W-1:0] v, input logic [EDGE_W-1:0] e,
                              input logic [SIGN_W-1:0] sg, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = sender_idles ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, sg, e, v};
        i_s_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        apply_entry(v, e, sg, lst);
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_VERTEX_COUNT) vertex_cfg = val[VCOUNT_W-1:0];
        else if (idx == CFG_EDGE_COUNT) edge_cfg = val[ECOUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] vdata,
                             input logic [CFG_DATA_W-1:0] edata);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_VERTEX_COUNT, vdata);
        write_reg(CFG_EDGE_COUNT, edata);
    endtask

    task automatic test_single_vertex();
        // Reset settings: one vertex, no edges.
        sender_idles = 1'b0;
        send_entry(5'd0, 6'd0, SIGN_OUT, 1'b1);
    endtask

    task automatic test_zero_vertex_count();
        configure(7'd0, 7'd0);
        send_entry(5'd31, 6'd63, SIGN_IN, 1'b1);
    endtask

    task automatic test_directed_cycle();
        configure(7'd3, 7'd3);
        send_entry(5'd0, 6'd0, SIGN_OUT, 1'b0);
        send_entry(5'd1, 6'd0, SIGN_IN, 1'b0);
        send_entry(5'd1, 6'd1, SIGN_OUT, 1'b0);
        send_entry(5'd2, 6'd1, SIGN_IN_ALT, 1'b0);
        send_entry(5'd2, 6'd2, SIGN_OUT, 1'b0);
        send_entry(5'd0, 6'd2, SIGN_IN, 1'b1);
    endtask

    task automatic test_rewrite_and_ignored();
        configure(7'd2, 7'd2);
        sender_idles = 1'b1;
        send_entry(5'd0, 6'd0, SIGN_OUT, 1'b0);
        send_entry(5'd1, 6'd0, SIGN_IN, 1'b0);
        // A zero sign drops the head that was just stored.
        send_entry(5'd1, 6'd0, SIGN_NONE, 1'b0);
        send_entry(5'd1, 6'd1, SIGN_OUT, 1'b0);
        send_entry(5'd0, 6'd1, SIGN_IN_ALT, 1'b0);
        // A vertex above the count and an edge above the count are both left out.
        send_entry(5'd31, 6'd1, SIGN_OUT, 1'b0);
        send_entry(5'd0, 6'd63, SIGN_OUT, 1'b0);
        send_entry(5'd1, 6'd63, SIGN_IN, 1'b0);
        send_entry(5'd0, 6'd1, SIGN_IN, 1'b1);
    endtask

    task automatic test_saturated_registers();
        configure(7'h7F, 7'h7F);
        send_entry(5'd31, 6'd63, SIGN_OUT, 1'b0);
        send_entry(5'd0, 6'd63, SIGN_IN, 1'b0);
        send_entry(5'd0, 6'd0, SIGN_OUT, 1'b0);
        send_entry(5'd31, 6'd0, SIGN_IN_ALT, 1'b1);
    endtask

    task automatic test_random_graphs();
        int                  sent, n_entries, nv, ne;
        logic [CFG_DATA_W-1:0] vdata, edata;
        logic [VERTEX_W-1:0] v;
        logic [EDGE_W-1:0]   e;
        logic [SIGN_W-1:0]   sg;
        sent = 0;
        while (sent < ITEMS_RANDOM) begin
            sender_idles = ($urandom_range(0, 3) != 0);
            if (sent == 0 || $urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       vdata = 7'd0;
                    1:       vdata = 7'd32;
                    2:       vdata = 7'd63;
                    default: vdata = CFG_DATA_W'($urandom_range(1, 8));
                endcase
                // The upper data bit is outside the vertex count field.
                vdata[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0:       edata = 7'd0;
                    1:       edata = 7'd64;
                    2:       edata = 7'd127;
                    default: edata = CFG_DATA_W'($urandom_range(1, 12));
                endcase
                configure(vdata, edata);
            end else if ($urandom_range(0, 1) == 1) begin
                // Hold the next graph back until the previous verdicts are out.
                wait_drained();
            end
            nv = clamp_vertices();
            ne = clamp_edges();
            n_entries = $urandom_range(3, 24);
            for (int i = 0; i < n_entries; i++) begin
                if ($urandom_range(0, 6) == 0) v = VERTEX_W'($urandom_range(0, 31));
                else v = VERTEX_W'($urandom_range(0, nv - 1));
                if (ne == 0 || $urandom_range(0, 6) == 0) e = EDGE_W'($urandom_range(0, 63));
                else e = EDGE_W'($urandom_range(0, ne - 1));
                sg = SIGN_W'($urandom_range(0, 3));
                send_entry(v, e, sg, i == n_entries - 1);
            end
            sent += n_entries;
        end
    endtask

    initial begin : sink_pattern
        t_sink_mode mode;
        int         span;
        int         phase;
        i_m_tready = 1'b0;
        phase = 0;
        forever begin
            mode = t_sink_mode'($urandom_range(0, 3));
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(negedge i_clk);
                phase++;
                case (mode)
                    SINK_OPEN:   i_m_tready <= 1'b1;
                    SINK_COIN:   i_m_tready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
                    default:     i_m_tready <= (phase % 4 != 3);
                endcase
            end
        end
    end

    task automatic flag_result(input string why, input t_verdict want, input t_verdict got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s: expected vertex %0d reach %0b last %0b, got %0d %0b %0b",
                     $realtime, why, want.vertex, want.reach, want.last,
                     got.vertex, got.reach, got.last);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_verdict.vertex = o_m_tdata[VERTEX_W-1:0];
            got_verdict.reach  = o_m_tdata[VERTEX_W];
            got_verdict.last   = o_m_tlast;
            if (verdict_q.size() == 0) begin
                flag_result("unexpected beat", '0, got_verdict);
            end else begin
                want_verdict = verdict_q.pop_front();
                if (got_verdict.vertex != want_verdict.vertex)
                    flag_result("result_vertex mismatch", want_verdict, got_verdict);
                if (got_verdict.reach != want_verdict.reach)
                    flag_result("reachable_from_all mismatch", want_verdict, got_verdict);
                if (got_verdict.last != want_verdict.last)
                    flag_result("last_result mismatch", want_verdict, got_verdict);
            end
        end
    end

    initial begin
        error_count  = 0;
        cycle_count  = 0;
        burst_left   = 0;
        sender_idles = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tlast    = 1'b0;
        vertex_cfg   = VCOUNT_W'(1);
        edge_cfg     = '0;
        clear_graph();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_single_vertex();
        test_zero_vertex_count();
        test_directed_cycle();
        test_rewrite_and_ignored();
        test_saturated_registers();
        test_random_graphs();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && verdict_q.size() == 0) begin
            $display("reachable_from_all_vertices_unit test passed");
        end else begin
            $display("reachable_from_all_vertices_unit test failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/rfav_pkg.sv
hw/rtl/rfav_ctrl.sv
hw/rtl/rfav_datapath.sv
hw/rtl/reachable_from_all_vertices_unit.sv
dv/reachable_from_all_vertices_unit_tb.sv
